[hw/rtl/rsrt_pkg.sv]
package rsrt_pkg;

    localparam int VALUE_W     = 32;
    localparam int TAG_W       = 5;
    localparam int REG_IDX_W   = 4;
    localparam int ROB_TAG_W   = 4;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 40;
    // wide enough to compare a 4-bit field against a parameter up to 64
    localparam int CMP_W       = 7;

    localparam logic [TAG_W-1:0] TAG_NONE = '1;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_RENAME = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_SHIFT  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                 rename;
        logic                 commit;
        logic                 shift;
        logic [ROB_TAG_W-1:0] tag;
    } tag_req_t;

    typedef struct packed {
        logic             busy;
        logic [TAG_W-1:0] tag;
        logic             hit;
    } tag_rsp_t;

    typedef struct packed {
        logic             is_read;
        logic             busy;
        logic [TAG_W-1:0] tag;
        logic             hit;
    } pend_t;

endpackage

[hw/rtl/register_status_rename_table.sv]
// Register status table: value, busy bit and reorder-buffer tag per register.
// Input beats on s_ carry one command each (read, rename, commit by tag,
// shift all tags down); every command yields exactly one result beat on m_.
// A result passes through the pending stage and then the output register before
// m_tvalid rises. One command is accepted per cycle while s_tready is high: the
// value memory is written by a commit at its own accepting edge, so a read in
// the very next cycle already sees it, and the tag search is a parallel compare
// over the tag flops.
// A pending stage and the output register part the two sides; when m_tready
// is low both fill and s_tready drops, and nothing is lost or repeated.
// Reset clears busy bits, sets every tag to none and marks all values unwritten
// (read as zero); there is no clearing pass, commands are taken right away.
// Read results carry value, busy and tag; other commands report value 0,
// busy 0, tag -1, and commit_hit tells whether a commit found its tag.
module register_status_rename_table #(
    parameter int NUM_REGS  = 16,
    parameter int ROB_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cmd[1:0], reg_index[5:2], rob_tag[9:6], write_value[41:10], zero fill
    input  logic [rsrt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // reg_value[31:0], reg_busy[32], reg_tag[37:33], commit_hit[38], zero fill
    output logic [rsrt_pkg::M_TDATA_W-1:0]    m_tdata
);
    import rsrt_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);

    cmd_t                 cmd;
    logic [CMP_W-1:0]     ri_ext;
    logic [CMP_W-1:0]     rt_ext;
    logic                 ri_ok;
    logic                 rt_ok;
    logic [IDX_W-1:0]     ri_idx;
    logic [VALUE_W-1:0]   wr_value;
    logic                 s_accept;
    logic                 pend_advance;

    tag_req_t             tag_req;
    tag_rsp_t             tag_rsp;
    logic [IDX_W-1:0]     hit_idx;
    logic [VALUE_W-1:0]   rd_data;

    pend_t                pend_reg, pend_next;
    logic                 pend_valid_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign cmd      = cmd_t'(s_tdata[1:0]);
    assign ri_ext   = {3'b000, s_tdata[5:2]};
    assign rt_ext   = {3'b000, s_tdata[9:6]};
    assign wr_value = s_tdata[41:10];
    assign ri_ok    = ri_ext < CMP_W'(NUM_REGS);
    assign rt_ok    = rt_ext < CMP_W'(ROB_DEPTH);
    assign ri_idx   = ri_ext[IDX_W-1:0];

    assign pend_advance = !m_tvalid_reg || m_tready;
    assign s_tready     = !pend_valid_reg || pend_advance;
    assign s_accept     = s_tvalid && s_tready;

    assign tag_req.rename = s_accept && (cmd == CMD_RENAME) && ri_ok && rt_ok;
    assign tag_req.commit = s_accept && (cmd == CMD_COMMIT);
    assign tag_req.shift  = s_accept && (cmd == CMD_SHIFT);
    assign tag_req.tag    = s_tdata[9:6];

    rsrt_tag_table #(
        .NUM_REGS (NUM_REGS)
    ) u_tag_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tag_req),
        .idx     (ri_idx),
        .rsp     (tag_rsp),
        .hit_idx (hit_idx)
    );

    rsrt_value_mem #(
        .NUM_REGS (NUM_REGS)
    ) u_value_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tag_req.commit && tag_rsp.hit),
        .wr_addr (hit_idx),
        .wr_data (wr_value),
        .rd_en   (s_accept && (cmd == CMD_READ)),
        .rd_addr (ri_idx),
        .rd_data (rd_data)
    );

    always_comb begin
        pend_next.is_read = (cmd == CMD_READ) && ri_ok;
        pend_next.busy    = pend_next.is_read ? tag_rsp.busy : 1'b0;
        pend_next.tag     = pend_next.is_read ? tag_rsp.tag : TAG_NONE;
        pend_next.hit     = (cmd == CMD_COMMIT) && tag_rsp.hit;
    end

    always_comb begin
        m_tdata_next = {1'b0, pend_reg.hit, pend_reg.tag, pend_reg.busy,
                        (pend_reg.is_read ? rd_data : VALUE_W'(0))};
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_reg <= pend_next;
        end
        if (pend_valid_reg && pend_advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_advance) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_valid_reg && pend_advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_fills_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> pend_valid_reg)
        else $error("accepted beat did not reach pending stage");

    a_pend_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !pend_advance) |=> (pend_valid_reg && $stable(pend_reg)))
        else $error("pending stage lost while output stalled");

    a_hit_only_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cmd != CMD_COMMIT) |=> !pend_reg.hit)
        else $error("commit hit flagged on non-commit");

    a_nonread_defaults: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cmd != CMD_READ) |=> (pend_reg.tag == TAG_NONE && !pend_reg.busy))
        else $error("non-read result carries register status");

    a_out_from_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(pend_valid_reg))
        else $error("output beat without pending item");

endmodule

[hw/rtl/rsrt_value_mem.sv]
module rsrt_value_mem #(
    parameter int NUM_REGS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   wr_en,
    input  logic [$clog2(NUM_REGS)-1:0]            wr_addr,
    input  logic [rsrt_pkg::VALUE_W-1:0]           wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2(NUM_REGS)-1:0]            rd_addr,
    output logic [rsrt_pkg::VALUE_W-1:0]           rd_data
);
    import rsrt_pkg::*;

    logic [VALUE_W-1:0]  mem [NUM_REGS];
    logic [NUM_REGS-1:0] written_reg;
    logic [VALUE_W-1:0]  rd_data_reg;
    logic                rd_written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

[hw/rtl/rsrt_tag_table.sv]
module rsrt_tag_table #(
    parameter int NUM_REGS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rsrt_pkg::tag_req_t            req,
    input  logic [$clog2(NUM_REGS)-1:0]   idx,
    output rsrt_pkg::tag_rsp_t            rsp,
    output logic [$clog2(NUM_REGS)-1:0]   hit_idx
);
    import rsrt_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);

    logic [NUM_REGS-1:0] busy_reg;
    logic [TAG_W-1:0]    tag_reg [NUM_REGS];
    logic [TAG_W-1:0]    key;
    logic                hit;

    assign key = {1'b0, req.tag};

    // lowest-numbered match wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (tag_reg[i] == key) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign rsp.busy = busy_reg[idx];
    assign rsp.tag  = tag_reg[idx];
    assign rsp.hit  = hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                tag_reg[i] <= TAG_NONE;
            end
        end else begin
            if (req.rename) begin
                busy_reg[idx] <= 1'b1;
                tag_reg[idx]  <= key;
            end
            if (req.commit && hit) begin
                busy_reg[hit_idx] <= 1'b0;
                tag_reg[hit_idx]  <= TAG_NONE;
            end
            if (req.shift) begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (!tag_reg[i][TAG_W-1]) begin
                        tag_reg[i] <= tag_reg[i] - TAG_W'(1);
                    end
                end
            end
        end
    end

endmodule

[bench/register_status_rename_table_tb.sv]
module register_status_rename_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsrt_pkg::*;

    localparam int NREGS          = 16;
    localparam int NROB           = 16;
    localparam int DRAIN_SLACK    = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               busy;
        logic [TAG_W-1:0]   tag;
        logic               hit;
    } status_rsp_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the table
    logic [VALUE_W-1:0] shadow_value [NREGS];
    logic               shadow_busy  [NREGS];
    logic [TAG_W-1:0]   shadow_tag   [NREGS];

    status_rsp_t pending_status_q[$];

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int rx_hold_left  = 0;
    int mismatch_cnt  = 0;
    int stall_cycles  = 0;

    register_status_rename_table #(
        .NUM_REGS  (NREGS),
        .ROB_DEPTH (NROB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic status_rsp_t predict_status(cmd_t op, logic [REG_IDX_W-1:0] ri,
                                                   logic [ROB_TAG_W-1:0] rt,
                                                   logic [VALUE_W-1:0] wv);
        status_rsp_t rsp;
        logic        found;
        rsp   = '{value: '0, busy: 1'b0, tag: TAG_NONE, hit: 1'b0};
        found = 1'b0;
        case (op)
            CMD_READ: begin
                if (int'(ri) < NREGS) begin
                    rsp.value = shadow_value[ri];
                    rsp.busy  = shadow_busy[ri];
                    rsp.tag   = shadow_tag[ri];
                end
            end
            CMD_RENAME: begin
                if (int'(ri) < NREGS && int'(rt) < NROB) begin
                    shadow_busy[ri] = 1'b1;
                    shadow_tag[ri]  = {1'b0, rt};
                end
            end
            CMD_COMMIT: begin
                for (int i = 0; i < NREGS; i++) begin
                    if (!found && shadow_tag[i] == {1'b0, rt}) begin
                        shadow_value[i] = wv;
                        shadow_busy[i]  = 1'b0;
                        shadow_tag[i]   = TAG_NONE;
                        found           = 1'b1;
                    end
                end
                rsp.hit = found;
            end
            default: begin
                // tag 0 wraps to none, busy kept
                for (int i = 0; i < NREGS; i++)
                    if (!shadow_tag[i][TAG_W-1])
                        shadow_tag[i] = shadow_tag[i] - 1'b1;
            end
        endcase
        return rsp;
    endfunction

    task automatic issue_command(cmd_t op, logic [REG_IDX_W-1:0] ri,
                                 logic [ROB_TAG_W-1:0] rt, logic [VALUE_W-1:0] wv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-42){1'b0}}, wv, rt, ri, op};
        do @(posedge aclk); while (!s_tready);
        pending_status_q.push_back(predict_status(op, ri, rt, wv));
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // receiver side: drives m_tready, checks each result beat
    always @(posedge aclk) begin
        status_rsp_t got;
        status_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{value: m_tdata[31:0], busy: m_tdata[32], tag: m_tdata[37:33],
                    hit: m_tdata[38]};
            if (pending_status_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result beat: value=%h busy=%b tag=%h hit=%b",
                             got.value, got.busy, got.tag, got.hit);
            end else begin
                want = pending_status_q.pop_front();
                if (got.value !== want.value || got.busy !== want.busy ||
                    got.tag !== want.tag || got.hit !== want.hit) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"mismatch: exp value=%h busy=%b tag=%h hit=%b,",
                                  " got value=%h busy=%b tag=%h hit=%b"},
                                 want.value, want.busy, want.tag, want.hit,
                                 got.value, got.busy, got.tag, got.hit);
                end
            end
        end
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        issue_command(CMD_READ,   4'd0,  4'd0,  32'h0000_0000);
        issue_command(CMD_READ,   4'd15, 4'd15, 32'hffff_ffff);
        issue_command(CMD_RENAME, 4'd0,  4'd0,  32'h0);
        issue_command(CMD_RENAME, 4'd15, 4'd15, 32'h0);
        issue_command(CMD_RENAME, 4'd3,  4'd15, 32'h0);
        // two registers share a tag: lowest one wins
        issue_command(CMD_COMMIT, 4'd0,  4'd15, 32'h7fff_ffff);
        issue_command(CMD_READ,   4'd3,  4'd0,  32'h0);
        issue_command(CMD_READ,   4'd15, 4'd0,  32'h0);
        issue_command(CMD_COMMIT, 4'd0,  4'd15, 32'h8000_0000);
        issue_command(CMD_READ,   4'd15, 4'd0,  32'h0);
        issue_command(CMD_COMMIT, 4'd0,  4'd9,  32'h1234_5678);
        // tag 0 falls to none, busy stays
        issue_command(CMD_SHIFT,  4'd0,  4'd0,  32'h0);
        issue_command(CMD_READ,   4'd0,  4'd0,  32'h0);
        issue_command(CMD_COMMIT, 4'd0,  4'd0,  32'h5555_5555);
        issue_command(CMD_RENAME, 4'd5,  4'd7,  32'h0);
        issue_command(CMD_RENAME, 4'd5,  4'd2,  32'h0);
        issue_command(CMD_COMMIT, 4'd0,  4'd7,  32'haaaa_aaaa);
        issue_command(CMD_SHIFT,  4'd0,  4'd0,  32'h0);
        issue_command(CMD_COMMIT, 4'd0,  4'd1,  32'hffff_ffff);
        issue_command(CMD_READ,   4'd5,  4'd0,  32'h0);
        issue_command(CMD_READ,   4'd0,  4'd0,  32'h0);
        wait_results_done();
    endtask

    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        int                   pick;
        int                   r;
        cmd_t                 op;
        logic [REG_IDX_W-1:0] ri;
        logic [ROB_TAG_W-1:0] rt;
        logic [VALUE_W-1:0]   wv;
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 35)      op = CMD_READ;
            else if (pick < 65) op = CMD_RENAME;
            else if (pick < 92) op = CMD_COMMIT;
            else                op = CMD_SHIFT;
            ri = REG_IDX_W'($urandom_range(NREGS-1));
            rt = ROB_TAG_W'($urandom_range(15));
            wv = $urandom;
            case ($urandom_range(19))
                0: wv = 32'h0000_0000;
                1: wv = 32'h7fff_ffff;
                2: wv = 32'h8000_0000;
                3: wv = 32'hffff_ffff;
                default: ;
            endcase
            // aim most commits at a live tag
            if (op == CMD_COMMIT && $urandom_range(99) < 80) begin
                r = $urandom_range(NREGS-1);
                if (!shadow_tag[r][TAG_W-1])
                    rt = shadow_tag[r][ROB_TAG_W-1:0];
            end
            issue_command(op, ri, rt, wv);
        end
        wait_results_done();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        rx_hold_left <= 60;
        @(posedge aclk);
        test_random(40, 0, 0);
    endtask

    initial begin
        for (int i = 0; i < NREGS; i++) begin
            shadow_value[i] = '0;
            shadow_busy[i]  = 1'b0;
            shadow_tag[i]   = TAG_NONE;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(180, 0, 0);
        test_random(180, 71, 0);
        test_random(180, 0, 71);
        test_random(180, 21, 21);
        test_backpressure();
        test_random(60, 50, 50);

        if (mismatch_cnt == 0 && pending_status_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[register_status_rename_table.f]
hw/rtl/rsrt_pkg.sv
hw/rtl/rsrt_value_mem.sv
hw/rtl/rsrt_tag_table.sv
hw/rtl/register_status_rename_table.sv
bench/register_status_rename_table_tb.sv
